/* design/cpe_pkg.sv */
`default_nettype none

package cpe_pkg;

   localparam int ADDR_BITS_DEF = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic classify;
      logic emit;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic slot_free;
      logic last_emit;
   } status_type;

endpackage

`default_nettype wire

/* design/cpe_if.sv */
`default_nettype none

interface cpe_req_if #(
   parameter int ADDR_BITS = cpe_pkg::ADDR_BITS_DEF
) ();
   localparam int LEN_W = $clog2(ADDR_BITS + 1);

   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] source_addr;
   logic [LEN_W-1:0]     source_len;
   logic [ADDR_BITS-1:0] exclude_addr;
   logic [LEN_W-1:0]     exclude_len;

   modport source (output valid, source_addr, source_len, exclude_addr, exclude_len,
                   input ready);
   modport sink (input valid, source_addr, source_len, exclude_addr, exclude_len,
                 output ready);
endinterface

interface cpe_rsp_if #(
   parameter int ADDR_BITS = cpe_pkg::ADDR_BITS_DEF
) ();
   localparam int LEN_W = $clog2(ADDR_BITS + 1);

   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] out_addr;
   logic [LEN_W-1:0]     out_len;
   logic                 empty_res;
   logic                 last;

   modport source (output valid, out_addr, out_len, empty_res, last, input ready);
   modport sink (input valid, out_addr, out_len, empty_res, last, output ready);
endinterface

`default_nettype wire

/* design/cpe_ctrl.sv */
`default_nettype none

module cpe_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire cpe_pkg::status_type status,
   output cpe_pkg::cmd_type         cmd
);

   cpe_pkg::state_type state_ff;
   cpe_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cpe_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cpe_pkg::ST_CLASSIFY;
            end
         end
         cpe_pkg::ST_CLASSIFY: begin
            state_in = cpe_pkg::ST_EMIT;
         end
         cpe_pkg::ST_EMIT: begin
            if (status.slot_free && status.last_emit) begin
               state_in = cpe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cpe_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         cpe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         cpe_pkg::ST_CLASSIFY: begin
            cmd.classify = 1'b1;
         end
         cpe_pkg::ST_EMIT: begin
            cmd.emit = status.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/cpe_datapath.sv */
`default_nettype none

module cpe_datapath #(
   parameter int ADDR_BITS = cpe_pkg::ADDR_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   cpe_req_if.sink               req,
   cpe_rsp_if.source             rsp,
   input  wire cpe_pkg::cmd_type cmd,
   output cpe_pkg::status_type   status
);

   localparam int LEN_W = $clog2(ADDR_BITS + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_BITS);
   localparam logic [ADDR_BITS-1:0] ALL_ONES = {ADDR_BITS{1'b1}};
   localparam logic [ADDR_BITS-1:0] TOP_BIT = {1'b1, {(ADDR_BITS-1){1'b0}}};

   function automatic logic [ADDR_BITS-1:0] net_mask(input logic [LEN_W-1:0] len);
      // A length of ADDR_BITS or more shifts every one out, giving a full mask.
      return ~(ALL_ONES >> len);
   endfunction

   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
      return (len > MAX_LEN) ? MAX_LEN : len;
   endfunction

   logic [ADDR_BITS-1:0] sa_ff, ea_ff;
   logic [LEN_W-1:0]     sl_ff, el_ff;
   logic [LEN_W-1:0]     lvl_ff, lvl_in;
   logic                 cover_ff, cover_in;
   logic                 inside_ff, inside_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0] out_addr_ff;
   logic [LEN_W-1:0]     out_len_ff;
   logic                 empty_ff, last_ff;

   logic [LEN_W-1:0]     sl_sat, el_sat;
   logic [ADDR_BITS-1:0] sib_addr;
   logic [ADDR_BITS-1:0] emit_addr;
   logic [LEN_W-1:0]     emit_len;
   logic                 emit_empty;

   assign sl_sat = sat_len(req.source_len);
   assign el_sat = sat_len(req.exclude_len);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sa_ff <= req.source_addr & net_mask(sl_sat);
         ea_ff <= req.exclude_addr & net_mask(el_sat);
         sl_ff <= sl_sat;
         el_ff <= el_sat;
      end
   end

   assign cover_in  = (el_ff <= sl_ff) && ((sa_ff & net_mask(el_ff)) == ea_ff);
   assign inside_in = (sl_ff < el_ff) && ((ea_ff & net_mask(sl_ff)) == sa_ff);

   always_comb begin
      lvl_in = lvl_ff;
      priority if (cmd.classify) begin
         lvl_in = sl_ff + LEN_W'(1);
      end else if (cmd.emit && inside_ff && !status.last_emit) begin
         lvl_in = lvl_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cover_ff  <= 1'b0;
         inside_ff <= 1'b0;
         lvl_ff    <= '0;
      end else begin
         if (cmd.classify) begin
            cover_ff  <= cover_in;
            inside_ff <= inside_in;
         end
         lvl_ff <= lvl_in;
      end
   end

   // Sibling at this level: the exclusion's prefix with its lowest network bit flipped.
   assign sib_addr = (ea_ff & net_mask(lvl_ff)) ^ (TOP_BIT >> (lvl_ff - LEN_W'(1)));

   always_comb begin
      priority if (cover_ff) begin
         emit_addr  = '0;
         emit_len   = '0;
         emit_empty = 1'b1;
      end else if (inside_ff) begin
         emit_addr  = sib_addr;
         emit_len   = lvl_ff;
         emit_empty = 1'b0;
      end else begin
         emit_addr  = sa_ff;
         emit_len   = sl_ff;
         emit_empty = 1'b0;
      end
   end

   assign status.slot_free = !rsp_valid_ff || rsp.ready;
   assign status.last_emit = !inside_ff || (lvl_ff == el_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_addr_ff <= emit_addr;
         out_len_ff  <= emit_len;
         empty_ff    <= emit_empty;
         last_ff     <= status.last_emit;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_addr  = out_addr_ff;
   assign rsp.out_len   = out_len_ff;
   assign rsp.empty_res = empty_ff;
   assign rsp.last      = last_ff;

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp.ready))
      else $error("result loaded over a transaction still waiting");

   // The level only means something while the descent is emitting.
   a_walk_level_bounded: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && inside_ff) |-> (lvl_ff <= el_ff))
      else $error("descent passed the exclusion length");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cover_ff) |=> (rsp_valid_ff && empty_ff && last_ff))
      else $error("empty result not flagged as last");

   a_one_class: assert property (@(posedge clock) disable iff (reset)
      !(cover_ff && inside_ff))
      else $error("prefix pair classified as both covered and inside");

endmodule

`default_nettype wire

/* design/cidr_prefix_exclusion.sv */
// The request is registered on acceptance and classified in ST_CLASSIFY; in ST_EMIT each
// result goes to the output register. An item yields n results (1 when disjoint or
// covered, exclude_len - source_len otherwise, up to 32 at /0 minus /32), one sibling
// prefix per cycle from the descent counter while the output is not stalled; a new
// request is taken only after the last result is loaded. Reset is synchronous, active
// high, clears the controller and the output valid; there is no clearing pass.
`default_nettype none

module cidr_prefix_exclusion #(
   parameter int ADDR_BITS = cpe_pkg::ADDR_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   cpe_req_if.sink   req_ch,
   cpe_rsp_if.source rsp_ch
);

   cpe_pkg::cmd_type    cmd;
   cpe_pkg::status_type status;

   cpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpe_datapath #(
      .ADDR_BITS (ADDR_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .rsp    (rsp_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule

`default_nettype wire

/* tb/cidr_prefix_exclusion_check.sv */
`default_nettype none

module cidr_prefix_exclusion_check (
   input  wire logic clock,
   input  wire logic reset,
   cpe_req_if        req_ch,
   cpe_rsp_if        rsp_ch,
   output int        mismatch_count,
   output int        expected_left
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AW = cpe_pkg::ADDR_BITS_DEF;
   localparam int LW = $clog2(AW + 1);

   typedef struct packed {
      logic [AW-1:0] addr;
      logic [LW-1:0] len;
      logic          empty_res;
      logic          last;
   } prefix_type;

   // Prefixes still owed by the block, oldest first.
   prefix_type remaining_q[$];

   function automatic logic [AW-1:0] network_mask(int unsigned len);
      if (len >= AW) return '1;
      return ~({AW{1'b1}} >> len);
   endfunction

   function automatic int unsigned clamp_len(logic [LW-1:0] len);
      return (len > AW) ? AW : int'(len);
   endfunction

   // Work out what is left of the source prefix once the excluded prefix is removed.
   function automatic void push_remaining_prefixes(logic [AW-1:0] src_addr,
                                                   logic [LW-1:0] src_len,
                                                   logic [AW-1:0] exc_addr,
                                                   logic [LW-1:0] exc_len);
      int unsigned   slen;
      int unsigned   elen;
      int unsigned   lvl;
      logic [AW-1:0] saddr;
      logic [AW-1:0] eaddr;
      logic [AW-1:0] sib;
      slen  = clamp_len(src_len);
      elen  = clamp_len(exc_len);
      saddr = src_addr & network_mask(slen);
      eaddr = exc_addr & network_mask(elen);
      if (elen <= slen && (saddr & network_mask(elen)) == eaddr) begin
         remaining_q.push_back('{addr: '0, len: '0, empty_res: 1'b1, last: 1'b1});
      end else if (!(slen < elen && (eaddr & network_mask(slen)) == saddr)) begin
         remaining_q.push_back('{addr: saddr, len: LW'(slen), empty_res: 1'b0, last: 1'b1});
      end else begin
         // Walk down toward the exclusion, keeping the half that does not hold it.
         for (lvl = slen + 1; lvl <= elen; lvl++) begin
            sib = (eaddr & network_mask(lvl)) ^ (AW'(1) << (AW - lvl));
            remaining_q.push_back('{addr: sib, len: LW'(lvl), empty_res: 1'b0,
                                    last: (lvl == elen)});
         end
      end
   endfunction

   function automatic void note_failure(string what, prefix_type want, prefix_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t: %s: expected addr %h len %0d empty %b last %b,",
                   " got addr %h len %0d empty %b last %b"},
                  $realtime, what, want.addr, want.len, want.empty_res, want.last,
                  got.addr, got.len, got.empty_res, got.last);
   endfunction

   initial begin
      mismatch_count = 0;
      expected_left  = 0;
   end

   always @(posedge clock) begin
      prefix_type got;
      prefix_type want;
      if (!reset) begin
         // Results are taken before new work so that a transaction is never
         // compared against an item accepted at the same edge.
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{addr: rsp_ch.out_addr, len: rsp_ch.out_len,
                    empty_res: rsp_ch.empty_res, last: rsp_ch.last};
            if (remaining_q.size() == 0) begin
               note_failure("unexpected result", '0, got);
            end else begin
               want = remaining_q.pop_front();
               if (want !== got) note_failure("result mismatch", want, got);
            end
         end
         if (req_ch.valid && req_ch.ready)
            push_remaining_prefixes(req_ch.source_addr, req_ch.source_len,
                                    req_ch.exclude_addr, req_ch.exclude_len);
      end
      expected_left <= remaining_q.size();
   end

endmodule

`default_nettype wire

/* tb/cidr_prefix_exclusion_tb.sv */
`default_nettype none

module cidr_prefix_exclusion_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AW = cpe_pkg::ADDR_BITS_DEF;
   localparam int LW = $clog2(AW + 1);

   typedef enum int {
      KIND_NESTED,
      KIND_COVERED,
      KIND_DISJOINT,
      KIND_NOISE
   } item_kind_type;

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   expected_left;

   cpe_req_if req_bus ();
   cpe_rsp_if rsp_bus ();

   cidr_prefix_exclusion uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   cidr_prefix_exclusion_check check_u (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_bus),
      .rsp_ch         (rsp_bus),
      .mismatch_count (mismatch_count),
      .expected_left  (expected_left)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly back to back, sometimes a short pause, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 15);
      if (r < 9) return 0;
      if (r < 13) return $urandom_range(1, 3);
      if (r < 15) return $urandom_range(4, 8);
      return $urandom_range(12, 24);
   endfunction

   // A full-length prefix is sometimes given with a length above the address
   // width, which the block must treat as full length.
   function automatic logic [LW-1:0] len_code(int len);
      if (len >= AW && $urandom_range(0, 3) == 0) return LW'($urandom_range(AW, 2**LW - 1));
      return LW'(len);
   endfunction

   task automatic send_item(input logic [AW-1:0] src_addr, input logic [LW-1:0] src_len,
                            input logic [AW-1:0] exc_addr, input logic [LW-1:0] exc_len,
                            input int gap);
      req_bus.valid        <= 1'b1;
      req_bus.source_addr  <= src_addr;
      req_bus.source_len   <= src_len;
      req_bus.exclude_addr <= exc_addr;
      req_bus.exclude_len  <= exc_len;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (expected_left != 0) @(posedge clock);
   endtask

   initial begin
      int run;
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
         rsp_bus.ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      #25_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      item_kind_type kind;
      int            slen;
      int            elen;
      int            d;
      int            gap;
      logic [AW-1:0] ea;
      logic [AW-1:0] sa;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.source_addr  <= '0;
      req_bus.source_len   <= '0;
      req_bus.exclude_addr <= '0;
      req_bus.exclude_len  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Whole space minus a single host gives the longest answer.
      send_item(32'h0000_0000, 6'd0, 32'hFFFF_FFFF, 6'd32, pick_gap());
      send_item(32'hFFFF_FFFF, 6'd32, 32'h0000_0000, 6'd0, pick_gap());
      send_item(32'h0A00_0000, 6'd8, 32'h0A00_0000, 6'd8, pick_gap());
      send_item(32'hC0A8_0101, 6'd32, 32'hC0A8_0101, 6'd32, pick_gap());
      send_item(32'h1234_5678, 6'd0, 32'h8765_4321, 6'd0, pick_gap());
      send_item(32'h0A00_0000, 6'd8, 32'h0B00_0000, 6'd8, pick_gap());
      send_item(32'hC0A8_0101, 6'd32, 32'hC0A8_0102, 6'd32, pick_gap());
      // Host bits on both sides must be masked off before anything else.
      send_item(32'h0AFF_FFFF, 6'd8, 32'h0A01_FFFF, 6'd16, pick_gap());
      send_item(32'hC0A8_0100, 6'd31, 32'hC0A8_0101, 6'd32, pick_gap());
      send_item(32'hDEAD_BEEF, 6'd63, 32'hDEAD_BEEF, 6'd40, pick_gap());
      send_item(32'h5555_AAAA, 6'd33, 32'hFFFF_FFFF, 6'd0, pick_gap());
      send_item(32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF, 6'd63, pick_gap());
      send_item(32'hFFFF_FFFF, 6'd24, 32'h0000_0000, 6'd32, pick_gap());
      send_item(32'h0A01_0000, 6'd16, 32'h0B00_0000, 6'd8, pick_gap());
      send_item(32'h0000_0000, 6'd0, 32'h8000_0000, 6'd1, pick_gap());
      send_item(32'hAC10_0001, 6'd32, 32'hAC10_0000, 6'd31, pick_gap());
      send_item(32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 6'd63, pick_gap());
      send_item(32'h0A01_0000, 6'd16, 32'h0A00_0000, 6'd8, pick_gap());
      send_item(32'h7FFF_FFFF, 6'd1, 32'h7FFF_FFFF, 6'd33, pick_gap());

      for (int i = 0; i < 500; i++) begin
         ea = $urandom;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: kind = KIND_NESTED;
            6:                kind = KIND_COVERED;
            7, 8:             kind = KIND_DISJOINT;
            default:          kind = KIND_NOISE;
         endcase
         case (kind)
            KIND_NESTED: begin
               slen = $urandom_range(0, AW - 1);
               if ($urandom_range(0, 1) == 0) begin
                  elen = slen + $urandom_range(1, 4);
                  if (elen > AW) elen = AW;
               end else begin
                  elen = $urandom_range(slen + 1, AW);
               end
               sa = ea ^ (32'($urandom) >> slen);
            end
            KIND_COVERED: begin
               elen = $urandom_range(0, AW);
               slen = $urandom_range(elen, AW);
               sa   = ea ^ (32'($urandom) >> elen);
            end
            KIND_DISJOINT: begin
               slen = $urandom_range(1, AW);
               elen = $urandom_range(1, AW);
               // The two prefixes first differ at bit d, which both of them fix.
               d    = $urandom_range(0, ((slen < elen) ? slen : elen) - 1);
               sa   = ea ^ (32'h8000_0000 >> d) ^ (32'($urandom) >> (d + 1));
            end
            default: begin
               sa   = $urandom;
               slen = $urandom_range(0, 2**LW - 1);
               elen = $urandom_range(0, 2**LW - 1);
            end
         endcase
         gap = ((i % 100) < 15) ? 0 : pick_gap();
         if (i == 250 || i == 499) gap = 1;
         send_item(sa, len_code(slen), ea, len_code(elen), gap);
         if (i == 250) wait_drained();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_left == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

/* cidr_prefix_exclusion.f */
design/cpe_pkg.sv
design/cpe_if.sv
design/cpe_ctrl.sv
design/cpe_datapath.sv
design/cidr_prefix_exclusion.sv
tb/cidr_prefix_exclusion_check.sv
tb/cidr_prefix_exclusion_tb.sv
